### hdl/bce_pkg.sv
// ----------------------------------------------------------------------------
// bce_pkg: shared types and constants of the Bezier curve evaluator
// Holds the field widths, the transfer structs of both channels, the codes
// of the actions, status values and datapath operations, and the saturation
// helper.
// ----------------------------------------------------------------------------
package bce_pkg;

  localparam int MAX_POINTS = 16;
  localparam int FRAC_BITS  = 16;

  // Fixed field widths of the channels.
  localparam int CW   = 32;
  localparam int T_W  = 17;
  localparam int PH_W = 5;

  // Derived widths.
  localparam int AW    = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  // Scratch values: coordinate differences scaled by the degree.
  localparam int SW    = CW + 1 + CNT_W;
  localparam int DW    = SW + 1;
  localparam int MW    = FRAC_BITS + 1;
  localparam int PW    = DW + MW + 1;

  localparam logic [MW-1:0] T_ONE  = MW'(1) << FRAC_BITS;
  localparam logic [PW-1:0] P_HALF = PW'(1) << (FRAC_BITS - 1);

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_CLEAR  = 2'd1,
    ACT_POINT  = 2'd2,
    ACT_DERIV  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_SAT  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_COPY = 2'd0,
    OP_DIFF = 2'd1,
    OP_LERP = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN,
    S_RES_RD,
    S_RES_WAIT,
    S_DONE
  } state_e;

  typedef struct packed {
    action_e                action;
    logic signed [CW-1:0]   px;
    logic signed [CW-1:0]   py;
    logic        [T_W-1:0]  t;
  } in_item_t;

  typedef struct packed {
    logic signed [CW-1:0]   x;
    logic signed [CW-1:0]   y;
    status_e                status;
    logic        [PH_W-1:0] points_held;
  } out_item_t;

  // Control of one coordinate lane.
  typedef struct packed {
    logic          v1;
    op_e           op;
    logic [MW-1:0] mul;
  } lane_ctl_t;

  typedef struct packed {
    logic signed [CW-1:0] val;
    logic                 hit;
  } sat_t;

  function automatic sat_t sat_coord(input logic signed [SW-1:0] v);
    sat_t r;
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] lo;
    hi = SW'($signed({1'b0, {(CW-1){1'b1}}}));
    lo = SW'($signed({1'b1, {(CW-1){1'b0}}}));
    if (v > hi) begin
      r.val = hi[CW-1:0];
      r.hit = 1'b1;
    end else if (v < lo) begin
      r.val = lo[CW-1:0];
      r.hit = 1'b1;
    end else begin
      r.val = v[CW-1:0];
      r.hit = 1'b0;
    end
    return r;
  endfunction

endpackage

### hdl/bezier_curve_evaluator.sv
// ----------------------------------------------------------------------------
// bezier_curve_evaluator: de Casteljau evaluation of a stored 2-D curve
// Appends, clears, and evaluates points and derivatives of a Bezier curve
// whose control points live in a small on-chip memory.
// ----------------------------------------------------------------------------
// Append and clear go straight to the done state, which offers the result once
// the output register is free. A point or a derivative first streams the control
// points through the lanes, then each triangle row from the scratch memory, with
// one scratch read per cycle and a drain after each triangle row.
// Only one item is in work at a time; the next is taken back in the idle state.
// Reset empties the store; memories are not cleared, only written entries are read.
// ----------------------------------------------------------------------------
module bezier_curve_evaluator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bce_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bce_pkg::out_item_t  out_data_o
);
  import bce_pkg::*;

  // Control state.
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  op_e               op_q, op_d;
  logic [AW-1:0]     last_q, last_d;
  logic [AW-1:0]     rd_idx_q, rd_idx_d;
  logic              out_valid_q, out_valid_d;

  // Write-tracking pipeline that follows the lane stages.
  logic              v1_q, v1_d;
  logic              w1_q, w1_d, w2_q, w3_q;
  logic [AW-1:0]     wa1_q, wa1_d, wa2_q, wa3_q;

  // Payload registers.
  logic [MW-1:0]        t_q, t_d;
  logic signed [CW-1:0] res_x_q, res_x_d, res_y_q, res_y_d;
  status_e              stat_q, stat_d;
  out_item_t            out_q, out_d;

  // Memory ports.
  logic                 cp_we, mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [2*CW-1:0]      cp_rdata;
  logic [2*SW-1:0]      sc_rdata;

  // Lane connections.
  lane_ctl_t            lane_ctl;
  logic signed [SW-1:0] cur_x, cur_y, lane_x, lane_y;
  logic [AW-1:0]        next_top;
  sat_t                 sat_x, sat_y;
  logic                 in_xfer;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A point is stored at the transfer of an append, if there is room.
  assign cp_we = in_xfer && (in_data_i.action == ACT_APPEND) &&
                 (count_q < CNT_W'(MAX_POINTS));

  bce_ram #(
    .Width (2 * CW),
    .Depth (MAX_POINTS)
  ) u_ctrl_ram (
    .clk_i   (clk_i),
    .we_i    (cp_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i ({in_data_i.px, in_data_i.py}),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (cp_rdata)
  );

  // The scratch memory holds one row of the de Casteljau triangle, updated
  // in place: entry i of the next row overwrites entry i of this row after
  // entry i + 1 has already been read.
  bce_ram #(
    .Width (2 * SW),
    .Depth (MAX_POINTS)
  ) u_scratch_ram (
    .clk_i   (clk_i),
    .we_i    (w3_q),
    .waddr_i (wa3_q),
    .wdata_i ({lane_x, lane_y}),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (sc_rdata)
  );

  // The first pass of an evaluation streams the control points; the
  // triangle rows stream the scratch memory. op_q stays fixed while data of
  // a pass is in flight, so it selects the source for the whole pass.
  always_comb begin
    if (op_q == OP_LERP) begin
      cur_x = $signed(sc_rdata[2*SW-1:SW]);
      cur_y = $signed(sc_rdata[SW-1:0]);
    end else begin
      cur_x = SW'($signed(cp_rdata[2*CW-1:CW]));
      cur_y = SW'($signed(cp_rdata[CW-1:0]));
    end
  end

  // Multiplier operand: the parameter for a row, the degree for the
  // derivative differences, and exactly one for a plain copy.
  always_comb begin
    lane_ctl.v1 = v1_q;
    lane_ctl.op = op_q;
    case (op_q)
      OP_LERP: lane_ctl.mul = t_q;
      OP_DIFF: lane_ctl.mul = MW'(count_q - CNT_W'(1));
      default: lane_ctl.mul = T_ONE;
    endcase
  end

  bce_lane u_lane_x (
    .clk_i (clk_i),
    .ctl_i (lane_ctl),
    .cur_i (cur_x),
    .res_o (lane_x)
  );

  bce_lane u_lane_y (
    .clk_i (clk_i),
    .ctl_i (lane_ctl),
    .cur_i (cur_y),
    .res_o (lane_y)
  );

  assign sat_x = sat_coord($signed(sc_rdata[2*SW-1:SW]));
  assign sat_y = sat_coord($signed(sc_rdata[SW-1:0]));

  // After the first pass the triangle has count points for a curve point and
  // count - 1 for a derivative; each later row is one shorter.
  assign next_top = (op_q == OP_COPY) ? last_q : (last_q - AW'(1));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    op_d        = op_q;
    last_d      = last_q;
    rd_idx_d    = rd_idx_q;
    t_d         = t_q;
    res_x_d     = res_x_q;
    res_y_d     = res_y_q;
    stat_d      = stat_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    v1_d        = 1'b0;
    w1_d        = 1'b0;
    wa1_d       = wa1_q;
    mem_re      = 1'b0;
    mem_raddr   = rd_idx_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          res_x_d  = '0;
          res_y_d  = '0;
          stat_d   = STAT_OK;
          rd_idx_d = '0;
          last_d   = count_q[AW-1:0] - AW'(1);
          if (32'(in_data_i.t) > 32'(T_ONE)) begin
            t_d = T_ONE;
          end else begin
            t_d = MW'(in_data_i.t);
          end
          state_d = S_DONE;
          unique case (in_data_i.action)
            ACT_APPEND: begin
              if (count_q < CNT_W'(MAX_POINTS)) begin
                count_d = count_q + CNT_W'(1);
              end else begin
                stat_d = STAT_FULL;
              end
            end
            ACT_CLEAR: begin
              count_d = '0;
            end
            ACT_POINT: begin
              if (count_q != '0) begin
                op_d    = OP_COPY;
                state_d = S_ISSUE;
              end
            end
            ACT_DERIV: begin
              if (count_q >= CNT_W'(2)) begin
                op_d    = OP_DIFF;
                state_d = S_ISSUE;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      // One memory read per cycle over indices 0 to last_q.
      S_ISSUE: begin
        mem_re = 1'b1;
        v1_d   = 1'b1;
        if (op_q == OP_COPY) begin
          w1_d  = 1'b1;
          wa1_d = rd_idx_q;
        end else begin
          w1_d  = (rd_idx_q != '0);
          wa1_d = rd_idx_q - AW'(1);
        end
        if (rd_idx_q == last_q) begin
          state_d = S_DRAIN;
        end else begin
          rd_idx_d = rd_idx_q + AW'(1);
        end
      end

      // Interlock: the next row reads entries this row is still writing,
      // so wait until the lane pipeline is empty.
      S_DRAIN: begin
        if (!(v1_q || w2_q || w3_q)) begin
          rd_idx_d = '0;
          if (op_q == OP_LERP) begin
            if (last_q == AW'(1)) begin
              state_d = S_RES_RD;
            end else begin
              last_d  = last_q - AW'(1);
              state_d = S_ISSUE;
            end
          end else begin
            if (next_top == '0) begin
              state_d = S_RES_RD;
            end else begin
              op_d    = OP_LERP;
              last_d  = next_top;
              state_d = S_ISSUE;
            end
          end
        end
      end

      S_RES_RD: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
        state_d   = S_RES_WAIT;
      end

      // Point results never leave the hull, so saturation only ever
      // triggers for derivatives.
      S_RES_WAIT: begin
        res_x_d = sat_x.val;
        res_y_d = sat_y.val;
        if (sat_x.hit || sat_y.hit) begin
          stat_d = STAT_SAT;
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d       = 1'b1;
          out_d.x           = res_x_q;
          out_d.y           = res_y_q;
          out_d.status      = stat_q;
          out_d.points_held = PH_W'(count_q);
          state_d           = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      op_q        <= OP_COPY;
      last_q      <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
      v1_q        <= 1'b0;
      w1_q        <= 1'b0;
      w2_q        <= 1'b0;
      w3_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      op_q        <= op_d;
      last_q      <= last_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
      v1_q        <= v1_d;
      w1_q        <= w1_d;
      w2_q        <= w1_q;
      w3_q        <= w2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q     <= t_d;
    res_x_q <= res_x_d;
    res_y_q <= res_y_d;
    stat_q  <= stat_d;
    out_q   <= out_d;
    wa1_q   <= wa1_d;
    wa2_q   <= wa1_q;
    wa3_q   <= wa2_q;
  end

endmodule

### hdl/bce_ram.sv
// ----------------------------------------------------------------------------
// bce_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered, so it appears
// in the cycle after the read enable.
// ----------------------------------------------------------------------------
module bce_ram #(
  parameter int Width = 64,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### hdl/bce_lane.sv
// ----------------------------------------------------------------------------
// bce_lane: datapath of one coordinate
// Takes a stream of values read from memory and forms, per neighboring pair,
// a rounded linear interpolation, a degree-scaled difference, or a plain
// copy. Stage one subtracts, stage two multiplies, stage three rounds and
// adds; the result feeds the scratch memory write port.
// ----------------------------------------------------------------------------
module bce_lane (
  input  logic                            clk_i,
  input  bce_pkg::lane_ctl_t              ctl_i,
  input  logic signed [bce_pkg::SW-1:0]   cur_i,
  output logic signed [bce_pkg::SW-1:0]   res_o
);
  import bce_pkg::*;

  logic signed [SW-1:0] prev_q;
  logic signed [DW-1:0] diff_d, diff_q;
  logic signed [SW-1:0] a_d, a_q, a2_q;
  logic signed [PW-1:0] prod_q;
  logic signed [PW-1:0] rnd;

  always_ff @(posedge clk_i) begin
    if (ctl_i.v1) begin
      prev_q <= cur_i;
    end
  end

  // The point copy is a lerp from zero at t equal to one.
  always_comb begin
    if (ctl_i.op == OP_COPY) begin
      diff_d = DW'(cur_i);
    end else begin
      diff_d = DW'(cur_i) - DW'(prev_q);
    end
    a_d = (ctl_i.op == OP_LERP) ? prev_q : '0;
  end

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    a_q    <= a_d;
    prod_q <= PW'(diff_q) * PW'($signed({1'b0, ctl_i.mul}));
    a2_q   <= a_q;
  end

  // Rounding is half up: add one half, then floor by arithmetic shift.
  assign rnd   = (prod_q + $signed(P_HALF)) >>> FRAC_BITS;
  assign res_o = (ctl_i.op == OP_DIFF) ? SW'(prod_q) : (a2_q + SW'(rnd));

endmodule
